[hw/rtl/mrti_pkg.sv]
// Shared types, register codes and saturation helper for the rate evaluator.
package mrti_pkg;

   typedef enum logic [2:0] {
      CSR_SPRING    = 3'd0,
      CSR_DAMPING   = 3'd1,
      CSR_DRIVE     = 3'd2,
      CSR_QUADRATIC = 3'd3,
      CSR_INV_MASS  = 3'd4,
      CSR_MODE      = 3'd5,
      CSR_COUNT     = 3'd6
   } csr_index_type;

   localparam logic [1:0] MODE_HOLD    = 2'd0;
   localparam logic [1:0] MODE_UNIFORM = 2'd1;

   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_EVAL = 1'b1;

   localparam logic signed [31:0] RST_SPRING    = -32'sd3276800;
   localparam logic signed [31:0] RST_DAMPING   = -32'sd655360;
   localparam logic signed [31:0] RST_DRIVE     = 32'sd65536;
   localparam logic signed [31:0] RST_QUADRATIC = 32'sd0;
   localparam logic [30:0]        RST_INV_MASS  = 31'd2150;
   localparam logic [1:0]         RST_MODE      = 2'd2;
   localparam logic [8:0]         RST_COUNT     = 9'd2;

   localparam logic signed [31:0] S32_MAX = 32'sh7fffffff;
   localparam logic signed [31:0] S32_MIN = 32'sh80000000;

   typedef struct packed {
      logic              func;
      logic [7:0]        sample_index;
      logic signed [31:0] sample_time;
      logic signed [31:0] sample_force;
      logic signed [31:0] eval_time;
      logic signed [31:0] position;
      logic signed [31:0] velocity;
   } req_type;

   typedef struct packed {
      logic signed [31:0] ext_force;
      logic signed [31:0] position_rate;
      logic signed [31:0] velocity_rate;
      logic signed [31:0] inertial_force;
   } rsp_type;

   function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
      logic signed [31:0] r;
      if (v > 68'sd2147483647) r = S32_MAX;
      else if (v < -68'sd2147483648) r = S32_MIN;
      else r = v[31:0];
      return r;
   endfunction

endpackage

[hw/rtl/msd_rate_with_table_interp.sv]
// Rate evaluator for a spring-damper system with a tabulated external force.
// A load item writes a (time, force) sample into the table.
// An evaluate item runs setup and multiply steps. If its time lies between
// the first and last table times, it also searches for the segment, reading
// the table entry by entry in linear or hold mode (uniform mode divides for
// the segment index instead), and, outside hold mode and for a segment of
// nonzero length, divides for the segment slope. A mass divide follows unless
// inv_mass is zero; the divider makes one quotient bit per cycle.
// Each result is shown on rsp_data for one cycle with rsp_valid high; the
// receiver cannot stall it, and busy falls in the cycle the result appears.
module msd_rate_with_table_interp #(
   parameter int TABLE_DEPTH = 256,
   parameter int FRAC_BITS   = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  mrti_pkg::req_type   req_data,
   output logic                rsp_valid,
   output mrti_pkg::rsp_type   rsp_data,
   input  logic                csr_we,
   input  logic [2:0]          csr_index,
   input  logic [31:0]         csr_wdata
);

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   typedef enum logic [27:0] {
      S_IDLE   = 28'h0000001,
      S_RD0    = 28'h0000002,
      S_RDL    = 28'h0000004,
      S_CHK    = 28'h0000008,
      S_UNI    = 28'h0000010,
      S_UNIW   = 28'h0000020,
      S_SCANRD = 28'h0000040,
      S_SCANT  = 28'h0000080,
      S_SEGA   = 28'h0000100,
      S_SEGB   = 28'h0000200,
      S_SEGC   = 28'h0000400,
      S_SEGM   = 28'h0000800,
      S_SEGD   = 28'h0001000,
      S_SEGW   = 28'h0002000,
      S_MK     = 28'h0004000,
      S_MB     = 28'h0008000,
      S_MD     = 28'h0010000,
      S_MV     = 28'h0020000,
      S_MVS    = 28'h0040000,
      S_MZ     = 28'h0080000,
      S_MSUM   = 28'h0100000,
      S_MSAT   = 28'h0200000,
      S_MVR    = 28'h0400000,
      S_MVRS   = 28'h0800000,
      S_MASS   = 28'h1000000,
      S_MASSW  = 28'h2000000,
      S_MI     = 28'h4000000,
      S_OUT    = 28'h8000000
   } phase_type;

   phase_type state_ff, state_in;

   // configuration
   logic signed [31:0] spring_ff, damping_ff, drive_ff, quad_ff;
   logic [30:0]        inv_mass_ff;
   logic [1:0]         mode_ff;
   logic [8:0]         count_ff;

   // item working registers
   logic signed [31:0] t_ff, t_in, x_ff, x_in, v_ff, v_in;
   logic signed [31:0] t0_ff, t0_in, f0_ff, f0_in;
   logic signed [31:0] ta_ff, ta_in, fa_ff, fa_in;
   logic signed [31:0] df_ff, df_in, dq_ff, dq_in, dt_ff, dt_in;
   logic signed [31:0] f_ff, f_in, tmp_ff, tmp_in, vrate_ff, vrate_in;
   logic signed [31:0] mass_ff, mass_in;
   logic [IDX_W-1:0]   n_ff, n_in;
   logic signed [67:0] acc_ff, acc_in;
   logic signed [65:0] prod_ff, prod_in;
   logic               rsp_valid_ff, rsp_valid_in;
   mrti_pkg::rsp_type  rsp_ff, rsp_in;

   // datapath helpers
   logic [CNT_W-1:0]   cnt;
   logic [IDX_W-1:0]   last_idx;
   logic               mul_en;
   logic signed [32:0] mul_a, mul_b;
   logic signed [65:0] mq;
   logic [IDX_W-1:0]   rd_addr;
   logic [63:0]        mem_q;
   logic signed [31:0] mem_time, mem_force;
   logic               mem_we;
   logic               div_start, div_done;
   logic [63:0]        div_dividend, div_q;
   logic [32:0]        div_divisor;
   logic signed [32:0] span, diff;
   logic signed [31:0] dt_w;
   logic signed [65:0] prod_abs, q_s;
   logic signed [32:0] dt_abs;

   always_comb begin
      if (count_ff == 9'd0) cnt = CNT_W'(1);
      else if (32'(count_ff) > TABLE_DEPTH) cnt = CNT_W'(TABLE_DEPTH);
      else cnt = CNT_W'(count_ff);
      last_idx = IDX_W'(cnt - CNT_W'(1));
   end

   assign mem_time  = mem_q[63:32];
   assign mem_force = mem_q[31:0];
   assign mq        = prod_ff >>> FRAC_BITS;
   assign span      = 33'(mem_time) - 33'(t0_ff);
   assign diff      = 33'(t_ff) - 33'(t0_ff);
   assign dt_w      = mrti_pkg::sat32(68'(mem_time) - 68'(ta_ff));
   assign prod_abs  = prod_ff[65] ? -prod_ff : prod_ff;
   assign dt_abs    = dt_ff[31] ? -(33'(dt_ff)) : 33'(dt_ff);
   assign q_s       = (prod_ff[65] ^ dt_ff[31]) ? -(66'(signed'({2'b00, div_q})))
                                                : 66'(signed'({2'b00, div_q}));

   assign mem_we = (state_ff == S_IDLE) && start && (req_data.func == mrti_pkg::FUNC_LOAD)
                   && (32'(req_data.sample_index) < TABLE_DEPTH);

   always_comb begin
      case (state_ff)
         S_RDL:    rd_addr = last_idx;
         S_CHK:    rd_addr = IDX_W'(1);
         S_SCANRD: rd_addr = n_ff;
         S_SEGA:   rd_addr = n_ff - IDX_W'(1);
         S_SEGB:   rd_addr = n_ff;
         default:  rd_addr = '0;
      endcase
   end

   always_comb begin
      mul_en = 1'b1;
      mul_a  = '0;
      mul_b  = '0;
      case (state_ff)
         S_SEGM: begin mul_a = 33'(df_ff);    mul_b = 33'(dq_ff); end
         S_MK:   begin mul_a = 33'(spring_ff); mul_b = 33'(x_ff); end
         S_MB:   begin mul_a = 33'(damping_ff); mul_b = 33'(v_ff); end
         S_MD:   begin mul_a = 33'(drive_ff); mul_b = 33'(f_ff); end
         S_MV:   begin mul_a = 33'(v_ff);     mul_b = 33'(v_ff); end
         S_MZ:   begin mul_a = 33'(quad_ff);  mul_b = 33'(tmp_ff); end
         S_MVR:  begin mul_a = 33'(tmp_ff);   mul_b = signed'({2'b00, inv_mass_ff}); end
         S_MI:   begin mul_a = 33'(mass_ff);  mul_b = 33'(vrate_ff); end
         S_MASSW, S_MASS, S_MVRS: mul_en = 1'b0;
         S_OUT:  mul_en = 1'b0;
         default: mul_en = 1'b0;
      endcase
   end

   always_comb begin
      div_start    = 1'b0;
      div_dividend = '0;
      div_divisor  = '0;
      case (state_ff)
         S_UNI: begin
            div_dividend = 64'(unsigned'(diff));
            div_divisor  = unsigned'(span);
         end
         S_SEGD: begin
            div_start    = 1'b1;
            div_dividend = prod_abs[63:0];
            div_divisor  = unsigned'(dt_abs);
         end
         S_MASS: begin
            div_dividend = 64'(1) << (2 * FRAC_BITS);
            div_divisor  = {2'b00, inv_mass_ff};
         end
         default: ;
      endcase
      if (state_ff == S_UNI && span > 33'sd0) div_start = 1'b1;
      if (state_ff == S_MASS && inv_mass_ff != '0) div_start = 1'b1;
   end

   always_comb begin
      state_in     = state_ff;
      t_in = t_ff;   x_in = x_ff;   v_in = v_ff;
      t0_in = t0_ff; f0_in = f0_ff; ta_in = ta_ff; fa_in = fa_ff;
      df_in = df_ff; dq_in = dq_ff; dt_in = dt_ff;
      f_in = f_ff;   tmp_in = tmp_ff; vrate_in = vrate_ff; mass_in = mass_ff;
      n_in = n_ff;   acc_in = acc_ff;
      prod_in      = mul_en ? mul_a * mul_b : prod_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      case (state_ff)
         S_IDLE: begin
            if (start && req_data.func == mrti_pkg::FUNC_EVAL) begin
               t_in     = req_data.eval_time;
               x_in     = req_data.position;
               v_in     = req_data.velocity;
               state_in = S_RD0;
            end
         end
         S_RD0: state_in = S_RDL;
         S_RDL: begin
            t0_in    = mem_time;
            f0_in    = mem_force;
            state_in = S_CHK;
         end
         S_CHK: begin
            if (t_ff <= t0_ff) begin
               f_in     = f0_ff;
               state_in = S_MK;
            end else if (mem_time <= t_ff) begin
               f_in     = mem_force;
               state_in = S_MK;
            end else if (mode_ff == mrti_pkg::MODE_UNIFORM) begin
               state_in = S_UNI;
            end else begin
               n_in     = IDX_W'(1);
               state_in = S_SCANRD;
            end
         end
         S_UNI: begin
            // time is past sample 0, so a non-positive span always lands on segment one
            if (span > 33'sd0) begin
               state_in = S_UNIW;
            end else begin
               n_in     = IDX_W'(1);
               state_in = S_SEGA;
            end
         end
         S_UNIW: begin
            if (div_done) begin
               if (div_q >= 64'(cnt - CNT_W'(1))) n_in = last_idx;
               else n_in = IDX_W'(div_q + 64'd1);
               state_in = S_SEGA;
            end
         end
         S_SCANRD: state_in = S_SCANT;
         S_SCANT: begin
            if ((CNT_W'(n_ff) < cnt - CNT_W'(1)) && (mem_time < t_ff)) begin
               n_in     = n_ff + IDX_W'(1);
               state_in = S_SCANRD;
            end else begin
               state_in = S_SEGA;
            end
         end
         S_SEGA: state_in = S_SEGB;
         S_SEGB: begin
            ta_in    = mem_time;
            fa_in    = mem_force;
            state_in = S_SEGC;
         end
         S_SEGC: begin
            if (mode_ff == mrti_pkg::MODE_HOLD || dt_w == 32'sd0) begin
               f_in     = fa_ff;
               state_in = S_MK;
            end else begin
               df_in    = mrti_pkg::sat32(68'(mem_force) - 68'(fa_ff));
               dq_in    = mrti_pkg::sat32(68'(t_ff) - 68'(ta_ff));
               dt_in    = dt_w;
               state_in = S_SEGM;
            end
         end
         S_SEGM: state_in = S_SEGD;
         S_SEGD: state_in = S_SEGW;
         S_SEGW: begin
            if (div_done) begin
               f_in     = mrti_pkg::sat32(68'(fa_ff) + 68'(q_s));
               state_in = S_MK;
            end
         end
         S_MK: begin
            acc_in   = '0;
            state_in = S_MB;
         end
         S_MB: begin
            acc_in   = acc_ff + 68'(mq);
            state_in = S_MD;
         end
         S_MD: begin
            acc_in   = acc_ff + 68'(mq);
            state_in = S_MV;
         end
         S_MV: begin
            acc_in   = acc_ff + 68'(mq);
            state_in = S_MVS;
         end
         S_MVS: begin
            tmp_in   = mrti_pkg::sat32(68'(mq));
            state_in = S_MZ;
         end
         S_MZ: state_in = S_MSUM;
         S_MSUM: begin
            acc_in   = acc_ff + 68'(mq);
            state_in = S_MSAT;
         end
         S_MSAT: begin
            tmp_in   = mrti_pkg::sat32(acc_ff);
            state_in = S_MVR;
         end
         S_MVR: state_in = S_MVRS;
         S_MVRS: begin
            vrate_in = mrti_pkg::sat32(68'(mq));
            state_in = S_MASS;
         end
         S_MASS: begin
            if (inv_mass_ff == '0) begin
               mass_in  = mrti_pkg::S32_MAX;
               state_in = S_MI;
            end else begin
               state_in = S_MASSW;
            end
         end
         S_MASSW: begin
            if (div_done) begin
               mass_in  = (div_q > 64'(32'h7fffffff)) ? mrti_pkg::S32_MAX
                                                      : signed'(div_q[31:0]);
               state_in = S_MI;
            end
         end
         // mass is positive and below 2^31, one pass through the shared multiplier
         S_MI: state_in = S_OUT;
         S_OUT: begin
            rsp_in.ext_force      = f_ff;
            rsp_in.position_rate  = v_ff;
            rsp_in.velocity_rate  = vrate_ff;
            rsp_in.inertial_force = mrti_pkg::sat32(68'(mq));
            rsp_valid_in          = 1'b1;
            state_in              = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         spring_ff    <= mrti_pkg::RST_SPRING;
         damping_ff   <= mrti_pkg::RST_DAMPING;
         drive_ff     <= mrti_pkg::RST_DRIVE;
         quad_ff      <= mrti_pkg::RST_QUADRATIC;
         inv_mass_ff  <= mrti_pkg::RST_INV_MASS;
         mode_ff      <= mrti_pkg::RST_MODE;
         count_ff     <= mrti_pkg::RST_COUNT;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (mrti_pkg::csr_index_type'(csr_index))
               mrti_pkg::CSR_SPRING:    spring_ff   <= csr_wdata;
               mrti_pkg::CSR_DAMPING:   damping_ff  <= csr_wdata;
               mrti_pkg::CSR_DRIVE:     drive_ff    <= csr_wdata;
               mrti_pkg::CSR_QUADRATIC: quad_ff     <= csr_wdata;
               mrti_pkg::CSR_INV_MASS:  inv_mass_ff <= csr_wdata[30:0];
               mrti_pkg::CSR_MODE:      mode_ff     <= csr_wdata[1:0];
               mrti_pkg::CSR_COUNT:     count_ff    <= csr_wdata[8:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      t_ff <= t_in;   x_ff <= x_in;   v_ff <= v_in;
      t0_ff <= t0_in; f0_ff <= f0_in; ta_ff <= ta_in; fa_ff <= fa_in;
      df_ff <= df_in; dq_ff <= dq_in; dt_ff <= dt_in;
      f_ff <= f_in;   tmp_ff <= tmp_in; vrate_ff <= vrate_in; mass_ff <= mass_in;
      n_ff <= n_in;   acc_ff <= acc_in; prod_ff <= prod_in;
      rsp_ff <= rsp_in;
   end

   mrti_mem #(
      .DEPTH  (TABLE_DEPTH),
      .ADDR_W (IDX_W)
   ) u_mem (
      .clock (clock),
      .we    (mem_we),
      .waddr (IDX_W'(req_data.sample_index)),
      .wdata ({req_data.sample_time, req_data.sample_force}),
      .raddr (rd_addr),
      .rdata (mem_q)
   );

   mrti_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_q)
   );

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_rsp_after_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(state_ff == S_OUT))
      else $error("result strobe without finished item");

   a_eval_goes_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.func == mrti_pkg::FUNC_EVAL) |=> busy)
      else $error("evaluate item did not start");

   a_div_done_waiting: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_UNIW || state_ff == S_SEGW || state_ff == S_MASSW))
      else $error("divider finished outside a wait state");

   a_scan_in_table: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCANT) |-> (CNT_W'(n_ff) < cnt))
      else $error("segment search ran past the table");

endmodule

[hw/rtl/mrti_mem.sv]
// Sample table: one write port, one read port, registered read data.
module mrti_mem #(
   parameter int DEPTH  = 256,
   parameter int ADDR_W = 8
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [63:0]       wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [63:0]       rdata
);

   logic [63:0] mem_ff [DEPTH];
   logic [63:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[hw/rtl/mrti_div.sv]
// Unsigned restoring divider, one quotient bit per cycle.
module mrti_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   input  logic [32:0] divisor,
   output logic        done,
   output logic [63:0] quotient
);

   logic [32:0] rem_ff, rem_in;
   logic [63:0] dq_ff, dq_in;
   logic [32:0] dsr_ff, dsr_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        run_ff, run_in;
   logic        done_ff, done_in;
   logic [33:0] rem_sh;
   logic        ge;

   always_comb begin
      rem_sh  = {rem_ff, dq_ff[63]};
      ge      = rem_sh >= {1'b0, dsr_ff};
      rem_in  = rem_ff;
      dq_in   = dq_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = '0;
         dq_in  = dividend;
         dsr_in = divisor;
         cnt_in = 7'd63;
         run_in = 1'b1;
      end else if (run_ff) begin
         rem_in = ge ? 33'(rem_sh - {1'b0, dsr_ff}) : rem_sh[32:0];
         dq_in  = {dq_ff[62:0], ge};
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dq_ff  <= dq_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = dq_ff;

endmodule

[tb/msd_rate_with_table_interp_tb.sv]
// Self-checking testbench for the table-driven spring-damper rate evaluator.
`timescale 1ns / 1ps

module msd_rate_with_table_interp_tb;

   localparam int DEPTH = 256;
   localparam int SETTLE = 800;  // worst evaluate latency plus margin
   localparam longint QMAX = 64'sd2147483647;
   localparam longint QMIN = -64'sd2147483648;

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   mrti_pkg::req_type req_data;
   logic              rsp_valid;
   mrti_pkg::rsp_type rsp_data;
   logic              csr_we;
   logic [2:0]        csr_index;
   logic [31:0]       csr_wdata;

   msd_rate_with_table_interp dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // predictor state
   longint     k_spring, b_damp, d_drive, z_quad, inv_mass;
   logic [1:0] lookup_mode;
   logic [8:0] table_count;
   longint     time_tab [DEPTH];
   longint     force_tab [DEPTH];

   mrti_pkg::rsp_type expected_rates [$];
   int      error_count;
   int      items_sent;
   bit      gaps_on;

   initial begin
      clock = 1'b0;
   end
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic longint clip32(longint v);
      if (v > QMAX) return QMAX;
      if (v < QMIN) return QMIN;
      return v;
   endfunction

   // product shifted down with floor rounding
   function automatic longint qmul(longint a, longint b);
      return (a * b) >>> 16;
   endfunction

   function automatic longint segment_force(int n, longint t);
      longint dts, df, dq;
      dts = clip32(time_tab[n] - time_tab[n-1]);
      if (dts == 0) return force_tab[n-1];
      df = clip32(force_tab[n] - force_tab[n-1]);
      dq = clip32(t - time_tab[n-1]);
      return clip32(force_tab[n-1] + (df * dq) / dts);
   endfunction

   function automatic longint table_force(longint t);
      int     cnt;
      int     n;
      longint span, q;
      cnt = table_count;
      n = 0;
      if (cnt < 1) cnt = 1;
      if (cnt > DEPTH) cnt = DEPTH;
      if (t <= time_tab[0]) return force_tab[0];
      if (time_tab[cnt-1] <= t) return force_tab[cnt-1];
      if (lookup_mode == mrti_pkg::MODE_UNIFORM) begin
         span = time_tab[1] - time_tab[0];
         if (span == 0) begin
            n = 1;
         end else begin
            q = (t - time_tab[0]) / span + 1;
            if (q < 1) q = 1;
            if (q > cnt - 1) q = cnt - 1;
            n = int'(q);
         end
         return segment_force(n, t);
      end
      while (n < cnt - 1 && time_tab[n] < t) n++;
      if (n < 1) n = 1;
      if (lookup_mode == mrti_pkg::MODE_HOLD) return force_tab[n-1];
      return segment_force(n, t);
   endfunction

   function automatic mrti_pkg::rsp_type rates_for(mrti_pkg::req_type r);
      mrti_pkg::rsp_type e;
      longint  t, x, v, f, sum, vrate, mass, inertial;
      t = longint'(r.eval_time);
      x = longint'(r.position);
      v = longint'(r.velocity);
      f = table_force(t);
      sum = clip32(qmul(k_spring, x) + qmul(b_damp, v) + qmul(d_drive, f)
                   + qmul(z_quad, clip32(qmul(v, v))));
      vrate = clip32(qmul(sum, inv_mass));
      if (inv_mass == 0) mass = QMAX;
      else mass = clip32((longint'(1) <<< 32) / inv_mass);
      inertial = clip32(qmul(mass, vrate));
      e.ext_force = f[31:0];
      e.position_rate = r.velocity;
      e.velocity_rate = vrate[31:0];
      e.inertial_force = inertial[31:0];
      return e;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("MISMATCH %s: got %0d want %0d at %0t", what, $signed(got),
               $signed(want), $realtime);
      error_count++;
   endtask

   always @(posedge clock) begin
      mrti_pkg::rsp_type want;
      if (!reset && rsp_valid) begin
         if (expected_rates.size() == 0) begin
            report_mismatch("unexpected result", rsp_data.ext_force, 32'd0);
         end else begin
            want = expected_rates.pop_front();
            if (rsp_data.ext_force !== want.ext_force)
               report_mismatch("ext_force", rsp_data.ext_force, want.ext_force);
            if (rsp_data.position_rate !== want.position_rate)
               report_mismatch("position_rate", rsp_data.position_rate,
                               want.position_rate);
            if (rsp_data.velocity_rate !== want.velocity_rate)
               report_mismatch("velocity_rate", rsp_data.velocity_rate,
                               want.velocity_rate);
            if (rsp_data.inertial_force !== want.inertial_force)
               report_mismatch("inertial_force", rsp_data.inertial_force,
                               want.inertial_force);
         end
      end
   end

   // start is left high after acceptance so back-to-back items need no toggle
   task automatic send_item(mrti_pkg::req_type r);
      start <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      items_sent++;
      if (r.func == mrti_pkg::FUNC_LOAD) begin
         time_tab[r.sample_index] = longint'(r.sample_time);
         force_tab[r.sample_index] = longint'(r.sample_force);
      end else begin
         expected_rates.push_back(rates_for(r));
      end
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
   endtask

   task automatic load_sample(int idx, logic [31:0] t, logic [31:0] f);
      mrti_pkg::req_type r;
      logic [223:0]      noise;
      noise = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
               $urandom()};
      r = noise[$bits(mrti_pkg::req_type)-1:0];
      r.func = mrti_pkg::FUNC_LOAD;
      r.sample_index = idx[7:0];
      r.sample_time = t;
      r.sample_force = f;
      send_item(r);
   endtask

   task automatic evaluate(logic [31:0] t, logic [31:0] x, logic [31:0] v);
      mrti_pkg::req_type r;
      logic [223:0]      noise;
      noise = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
               $urandom()};
      r = noise[$bits(mrti_pkg::req_type)-1:0];
      r.func = mrti_pkg::FUNC_EVAL;
      r.eval_time = t;
      r.position = x;
      r.velocity = v;
      send_item(r);
   endtask

   // wait for all results, then for any load still in flight
   task automatic drain();
      start <= 1'b0;
      while (expected_rates.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_csr(mrti_pkg::csr_index_type idx, logic [31:0] data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         mrti_pkg::CSR_SPRING:    k_spring = longint'($signed(data));
         mrti_pkg::CSR_DAMPING:   b_damp = longint'($signed(data));
         mrti_pkg::CSR_DRIVE:     d_drive = longint'($signed(data));
         mrti_pkg::CSR_QUADRATIC: z_quad = longint'($signed(data));
         mrti_pkg::CSR_INV_MASS:  inv_mass = longint'(data[30:0]);
         mrti_pkg::CSR_MODE:      lookup_mode = data[1:0];
         mrti_pkg::CSR_COUNT:     table_count = data[8:0];
         default: ;
      endcase
   endtask

   task automatic test_defaults();
      load_sample(0, 32'sd0, 32'sd131072);
      load_sample(1, 32'sd655360, -32'sd196608);
      evaluate(-32'sd327680, 32'sd65536, 32'sd32768);
      evaluate(32'sd0, -32'sd65536, 32'sd0);
      evaluate(32'sd327680, 32'sd100000, -32'sd70000);
      evaluate(32'sd655360, 32'sd0, 32'sd65536);
      evaluate(mrti_pkg::S32_MAX, mrti_pkg::S32_MIN, mrti_pkg::S32_MAX);
   endtask

   // duplicate time at slots 1 and 2 gives a zero-length segment
   task automatic test_modes();
      drain();
      write_csr(mrti_pkg::CSR_COUNT, 32'd4);
      load_sample(2, 32'sd655360, 32'sd196608);
      load_sample(3, 32'sd1310720, 32'sd262144);
      for (int m = 0; m < 4; m++) begin
         drain();
         write_csr(mrti_pkg::CSR_MODE, m);
         evaluate(32'sd983040, 32'sd65536, -32'sd65536);
         evaluate(32'sd200000, 32'sd0, 32'sd1000);
      end
      drain();
      write_csr(mrti_pkg::CSR_COUNT, 32'd1);
      evaluate(32'sd500000, 32'sd1, 32'sd1);
      drain();
      write_csr(mrti_pkg::CSR_COUNT, 32'd0);
      evaluate(-32'sd1, 32'sd1, 32'sd1);
   endtask

   task automatic test_extremes();
      drain();
      write_csr(mrti_pkg::CSR_COUNT, 32'd2);
      write_csr(mrti_pkg::CSR_MODE, 32'd2);
      write_csr(mrti_pkg::CSR_SPRING, 32'h7fffffff);
      write_csr(mrti_pkg::CSR_DAMPING, 32'h80000000);
      write_csr(mrti_pkg::CSR_DRIVE, 32'h7fffffff);
      write_csr(mrti_pkg::CSR_QUADRATIC, 32'h80000000);
      write_csr(mrti_pkg::CSR_INV_MASS, 32'hffffffff);
      load_sample(0, mrti_pkg::S32_MIN, mrti_pkg::S32_MIN);
      load_sample(1, mrti_pkg::S32_MAX, mrti_pkg::S32_MAX);
      evaluate(32'sd0, mrti_pkg::S32_MAX, mrti_pkg::S32_MIN);
      evaluate(32'sd12345, mrti_pkg::S32_MIN, mrti_pkg::S32_MAX);
      drain();
      write_csr(mrti_pkg::CSR_INV_MASS, 32'd0);
      write_csr(mrti_pkg::CSR_QUADRATIC, 32'h7fffffff);
      evaluate(-32'sd99999, mrti_pkg::S32_MAX, mrti_pkg::S32_MAX);
      evaluate(mrti_pkg::S32_MIN, 32'sd0, 32'sd0);
   endtask

   function automatic logic [31:0] pick_coeff();
      if ($urandom_range(0, 5) == 0) return $urandom();
      return $urandom_range(0, 32'h00ffffff) - 32'h00800000;
   endfunction

   function automatic logic [31:0] pick_state();
      if ($urandom_range(0, 5) == 0) return $urandom();
      return $urandom_range(0, 32'h00800000) - 32'h00400000;
   endfunction

   task automatic random_phase(int evals);
      int     sel, cnt_eff, i;
      longint t, step;
      logic [31:0] cnt_raw, im;
      sel = $urandom_range(0, 19);
      case (sel)
         0: cnt_raw = 256;
         1: cnt_raw = 0;
         2: cnt_raw = 1;
         3: cnt_raw = $urandom_range(257, 511) | ($urandom() & 32'hfffffe00);
         default: cnt_raw = $urandom_range(2, 16);
      endcase
      cnt_eff = cnt_raw[8:0];
      if (cnt_eff < 1) cnt_eff = 1;
      if (cnt_eff > DEPTH) cnt_eff = DEPTH;
      drain();
      write_csr(mrti_pkg::CSR_SPRING, pick_coeff());
      write_csr(mrti_pkg::CSR_DAMPING, pick_coeff());
      write_csr(mrti_pkg::CSR_DRIVE, pick_coeff());
      write_csr(mrti_pkg::CSR_QUADRATIC, pick_coeff());
      case ($urandom_range(0, 7))
         0: im = 32'd0;
         1: im = $urandom();
         default: im = $urandom_range(1, 70000);
      endcase
      write_csr(mrti_pkg::CSR_INV_MASS, im);
      write_csr(mrti_pkg::CSR_MODE, $urandom_range(0, 3) | ($urandom() & 32'hfffffffc));
      write_csr(mrti_pkg::CSR_COUNT, cnt_raw);
      // mostly ascending time tables; some with arbitrary times
      t = longint'($urandom_range(0, 32'h01ffffff)) - 64'sh01000000;
      for (i = 0; i < cnt_eff; i++) begin
         if ($urandom_range(0, 7) == 0) begin
            load_sample(i, $urandom(), $urandom());
         end else begin
            load_sample(i, 32'(clip32(t)), pick_state());
            step = $urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 32'h00100000);
            t = t + step;
         end
      end
      for (int e = 0; e < evals; e++) begin
         i = $urandom_range(0, cnt_eff - 1);
         case ($urandom_range(0, 4))
            0: t = longint'($signed($urandom()));
            1: t = time_tab[i];
            2: t = time_tab[i] + longint'($urandom_range(0, 64)) - 32;
            default: begin
               if (i + 1 < cnt_eff)
                  t = time_tab[i] + (time_tab[i+1] - time_tab[i])
                      * longint'($urandom_range(0, 1000)) / 1000;
               else
                  t = time_tab[i] - longint'($urandom_range(0, 1000));
            end
         endcase
         evaluate(32'(clip32(t)), pick_state(), pick_state());
      end
   endtask

   task automatic test_random();
      while (items_sent < 1450) begin
         if (items_sent > 1300) gaps_on = 1'b0;
         random_phase($urandom_range(25, 50));
      end
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      error_count = 0;
      items_sent = 0;
      gaps_on = 1'b1;
      k_spring = longint'(mrti_pkg::RST_SPRING);
      b_damp = longint'(mrti_pkg::RST_DAMPING);
      d_drive = longint'(mrti_pkg::RST_DRIVE);
      z_quad = longint'(mrti_pkg::RST_QUADRATIC);
      inv_mass = longint'(mrti_pkg::RST_INV_MASS);
      lookup_mode = mrti_pkg::RST_MODE;
      table_count = mrti_pkg::RST_COUNT;
      foreach (time_tab[i]) begin
         time_tab[i] = 0;
         force_tab[i] = 0;
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_defaults();
      test_modes();
      test_extremes();
      test_random();
      start <= 1'b0;
      while (expected_rates.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #20000000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
